FILE: design/sphc_pkg.sv
// Package with the shared types and constants of the stepper step/direction controller.
`timescale 1ns / 1ps

package sphc_pkg;

    // Default width of the stored axis position and step counter.
    localparam int POSITION_WIDTH_DEF = 16;

    // Reset value of the half-period register, in ticks.
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd600;

    // Width of the configuration address and data buses.
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // Register index of the half-period register.
    localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

    // Request codes carried by an input beat.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_HOME = 2'd2;

    // Axis operating mode.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_HOME = 2'd2
    } mode_t;

    // One input beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] target;
        logic        limit_switch;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic        motor_enable;
        logic        direction;
        logic        step_pulse;
        logic [15:0] position;
        logic        busy_res;
    } out_beat_t;

endpackage

FILE: design/stepper_position_homing_ctrl.sv
// Top level of the stepper step/direction controller with homing.
//
//  channel | signals                              | direction | purpose
//  --------+--------------------------------------+-----------+----------------------------
//  in      | in_valid, in_stall, in_data          | input     | tick, move and home beats
//  out     | out_valid, out_stall, out_data       | output    | one result beat per input
//  cfg     | psel, penable, pwrite, paddr, pwdata,| both      | half-period register
//          | prdata, pready                       |           |
//
// Each input beat is processed in the cycle it is accepted: the axis state and
// the output or skid register update on that edge, so one beat per cycle is
// sustained unless in stalls. The result is registered on out; a skid register
// holds a second result when out stalls, and in stalls only while it is full.
// Reset clears the axis state to idle at position zero and loads a half period
// of 600 ticks. There is no clearing pass.
`timescale 1ns / 1ps

module stepper_position_homing_ctrl #(
    parameter int POS_WIDTH = sphc_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  sphc_pkg::in_beat_t                   in_data,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output sphc_pkg::out_beat_t                  out_data,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sphc_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [sphc_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [sphc_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready
);

    // Configuration register.
    logic [15:0] half_period_reg;

    // Axis state.
    logic [POS_WIDTH-1:0] position_reg, position_next;
    logic [POS_WIDTH-1:0] steps_left_reg, steps_left_next;
    logic [15:0]          phase_timer_reg, phase_timer_next;
    sphc_pkg::mode_t      mode_reg, mode_next;
    logic                 pulse_reg, pulse_next;
    logic                 dir_reg, dir_next;
    logic                 enable_reg, enable_next;

    // Output register and skid stage.
    sphc_pkg::out_beat_t  out_beat_reg, out_beat_next;
    logic                 out_valid_reg, out_valid_next;
    sphc_pkg::out_beat_t  skid_beat_reg, skid_beat_next;
    logic                 skid_valid_reg, skid_valid_next;

    // Decoded events of the accepted beat.
    logic                 in_fire;
    logic                 out_fire;
    logic [POS_WIDTH-1:0] target_ext;
    logic [POS_WIDTH-1:0] steps_dec;
    logic [15:0]          timer_inc;
    logic                 tick_go;
    logic                 phase_end;
    logic                 low_end;
    logic                 move_go;
    logic                 home_go;
    logic                 target_above;
    logic                 cfg_write;
    sphc_pkg::out_beat_t  result;

    // Handshake.
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    // Configuration port: single register, selected when address bit 2 is zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == sphc_pkg::REG_HALF_PERIOD);

    always_comb
    begin
        if (paddr[2] == sphc_pkg::REG_HALF_PERIOD)
        begin
            prdata = {16'd0, half_period_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= sphc_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            half_period_reg <= pwdata[15:0];
        end
    end

    // Event decode for the beat on the input.
    always_comb
    begin
        target_ext   = POS_WIDTH'(in_data.target);
        steps_dec    = steps_left_reg - POS_WIDTH'(1);
        timer_inc    = phase_timer_reg + 16'd1;
        target_above = target_ext > position_reg;
        tick_go      = (in_data.req_type == sphc_pkg::REQ_TICK)
                       && (mode_reg != sphc_pkg::MODE_IDLE);
        phase_end    = tick_go && !(timer_inc < half_period_reg);
        low_end      = phase_end && !pulse_reg;
        move_go      = (in_data.req_type == sphc_pkg::REQ_MOVE)
                       && (mode_reg == sphc_pkg::MODE_IDLE)
                       && (target_ext != position_reg);
        home_go      = (in_data.req_type == sphc_pkg::REQ_HOME)
                       && (mode_reg == sphc_pkg::MODE_IDLE);
    end

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (move_go)
        begin
            mode_next = sphc_pkg::MODE_MOVE;
        end
        else if (home_go)
        begin
            if (in_data.limit_switch)
            begin
                mode_next = sphc_pkg::MODE_HOME;
            end
        end
        else if (low_end)
        begin
            case (mode_reg)
                sphc_pkg::MODE_MOVE:
                begin
                    if (steps_dec == '0)
                    begin
                        mode_next = sphc_pkg::MODE_IDLE;
                    end
                end
                sphc_pkg::MODE_HOME:
                begin
                    if (!in_data.limit_switch)
                    begin
                        mode_next = sphc_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Position, step counter, timer and line levels.
    always_comb
    begin
        position_next    = position_reg;
        steps_left_next  = steps_left_reg;
        phase_timer_next = phase_timer_reg;
        pulse_next       = pulse_reg;
        dir_next         = dir_reg;
        enable_next      = enable_reg;
        if (move_go)
        begin
            enable_next      = 1'b1;
            dir_next         = target_above;
            steps_left_next  = target_above ? (target_ext - position_reg)
                                            : (position_reg - target_ext);
            position_next    = target_ext;
            pulse_next       = 1'b1;
            phase_timer_next = '0;
        end
        else if (home_go)
        begin
            enable_next = 1'b1;
            dir_next    = 1'b0;
            if (!in_data.limit_switch)
            begin
                position_next = '0;
            end
            else
            begin
                pulse_next       = 1'b1;
                phase_timer_next = '0;
            end
        end
        else if (tick_go)
        begin
            if (!phase_end)
            begin
                phase_timer_next = timer_inc;
            end
            else
            begin
                phase_timer_next = '0;
                if (pulse_reg)
                begin
                    pulse_next = 1'b0;
                end
                else if (mode_reg == sphc_pkg::MODE_MOVE)
                begin
                    // A full step is done; start the next one if any remain.
                    steps_left_next = steps_dec;
                    pulse_next      = (steps_dec != '0);
                end
                else if (!in_data.limit_switch)
                begin
                    // Switch reached at the end of a low phase.
                    position_next = '0;
                end
                else
                begin
                    pulse_next = 1'b1;
                end
            end
        end
    end

    // Result of the beat, taken after the update.
    always_comb
    begin
        result.motor_enable = enable_next;
        result.direction    = dir_next;
        result.step_pulse   = pulse_next;
        result.position     = 16'(position_next);
        result.busy_res     = (mode_next != sphc_pkg::MODE_IDLE);
    end

    // Output register with skid stage.
    always_comb
    begin
        out_beat_next   = out_beat_reg;
        out_valid_next  = out_valid_reg;
        skid_beat_next  = skid_beat_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_beat_next   = skid_beat_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_beat_next  = result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_beat_next  = result;
                out_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            steps_left_reg  <= '0;
            phase_timer_reg <= '0;
            mode_reg        <= sphc_pkg::MODE_IDLE;
            pulse_reg       <= 1'b0;
            dir_reg         <= 1'b0;
            enable_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                position_reg    <= position_next;
                steps_left_reg  <= steps_left_next;
                phase_timer_reg <= phase_timer_next;
                mode_reg        <= mode_next;
                pulse_reg       <= pulse_next;
                dir_reg         <= dir_next;
                enable_reg      <= enable_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_beat_reg  <= out_beat_next;
        skid_beat_reg <= skid_beat_next;
    end

    // The skid stage only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    // Any running operation was started with the driver enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != sphc_pkg::MODE_IDLE) |-> enable_reg)
        else $error("axis busy with the driver disabled");

    // A move always has steps left to issue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sphc_pkg::MODE_MOVE) |-> (steps_left_reg != '0))
        else $error("move running with no steps left");

    // Operations end only after a low phase, so an idle axis has its step line low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sphc_pkg::MODE_IDLE) |-> !pulse_reg)
        else $error("step line high while idle");

endmodule
